>>> hw/rtl/mpqh_pkg.sv
// ----------------------------------------------------------------------------
// mpqh_pkg
// Shared types, codes and constant tables of the linear-probe hash table.
// ----------------------------------------------------------------------------
package mpqh_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SIZE_W = SLOT_W + 1;
    localparam int HASH_W = 32;
    localparam int DIV_CNT_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] SEED_ONE = 32'h7FED7FED;
    localparam logic [HASH_W-1:0] SEED_TWO = 32'hEEEEEEEE;
    localparam int unsigned LCG_START = 32'h00100001;
    localparam int unsigned LCG_MUL   = 125;
    localparam int unsigned LCG_MOD   = 32'h002AAAAB;
    localparam int unsigned CRYPT_SETS = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_REMOVED   = 3'd5;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd6;

    localparam logic [1:0] KIND_OFFSET = 2'd0;
    localparam logic [1:0] KIND_CHECK_A = 2'd1;
    localparam logic [1:0] KIND_CHECK_B = 2'd2;

    localparam logic [2:0] REG_TABLE_SIZE = 3'd0;
    localparam logic [10:0] TABLE_SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_byte;
        logic       last_byte;
        logic [9:0] slot_index;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] slot;
    } out_beat_t;

    typedef struct packed {
        logic              used;
        logic [HASH_W-1:0] chk_a;
        logic [HASH_W-1:0] chk_b;
    } slot_entry_t;

    typedef struct packed {
        logic       step;
        logic       restart;
        logic [1:0] kind;
    } fold_ctrl_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_FOLD,
        FSM_HASH,
        FSM_MOD,
        FSM_PROBE_RD,
        FSM_PROBE_CMP,
        FSM_EMIT
    } fsm_t;

    typedef logic [HASH_W-1:0] crypt_row_t [256];

    // Builds the part of the crypt word table that belongs to one hash kind.
    function automatic crypt_row_t crypt_row(input int unsigned kind);
        crypt_row_t  r;
        int unsigned seed;
        int unsigned hi;
        seed = LCG_START;
        for (int row = 0; row < 256; row++) begin
            for (int unsigned k = 0; k < CRYPT_SETS; k++) begin
                seed = (seed * LCG_MUL + 3) % LCG_MOD;
                hi   = (seed & 32'h0000FFFF) << 16;
                seed = (seed * LCG_MUL + 3) % LCG_MOD;
                if (k == kind) begin
                    r[row] = hi | (seed & 32'h0000FFFF);
                end
            end
        end
        return r;
    endfunction

    localparam crypt_row_t CRYPT_OFFSET  = crypt_row(0);
    localparam crypt_row_t CRYPT_CHECK_A = crypt_row(1);
    localparam crypt_row_t CRYPT_CHECK_B = crypt_row(2);

endpackage

>>> hw/rtl/mpqh_ram.sv
// ----------------------------------------------------------------------------
// mpqh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mpqh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/mpqh_fold.sv
// ----------------------------------------------------------------------------
// mpqh_fold
// Seed registers of the three one-way hashes and one shared fold unit.
// ----------------------------------------------------------------------------
module mpqh_fold (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mpqh_pkg::fold_ctrl_t      ctrl,
    input  logic [7:0]                ch,
    output logic [mpqh_pkg::HASH_W-1:0] hash_offset,
    output logic [mpqh_pkg::HASH_W-1:0] hash_a,
    output logic [mpqh_pkg::HASH_W-1:0] hash_b
);
    import mpqh_pkg::*;

    logic [HASH_W-1:0] s1_reg [3];
    logic [HASH_W-1:0] s2_reg [3];
    logic [HASH_W-1:0] s1_sel, s2_sel, cw, n1, n2;

    // One fold step for the kind that the sequencer selects.
    always_comb begin
        unique case (ctrl.kind)
            KIND_CHECK_A: begin
                s1_sel = s1_reg[1];
                s2_sel = s2_reg[1];
                cw     = CRYPT_CHECK_A[ch];
            end
            KIND_CHECK_B: begin
                s1_sel = s1_reg[2];
                s2_sel = s2_reg[2];
                cw     = CRYPT_CHECK_B[ch];
            end
            default: begin
                s1_sel = s1_reg[0];
                s2_sel = s2_reg[0];
                cw     = CRYPT_OFFSET[ch];
            end
        endcase
        n1 = cw ^ (s1_sel + s2_sel);
        n2 = {24'd0, ch} + n1 + s2_sel + (s2_sel << 5) + 32'd3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.restart) begin
            for (int i = 0; i < 3; i++) begin
                s1_reg[i] <= SEED_ONE;
                s2_reg[i] <= SEED_TWO;
            end
        end else if (ctrl.step) begin
            unique case (ctrl.kind)
                KIND_CHECK_A: begin
                    s1_reg[1] <= n1;
                    s2_reg[1] <= n2;
                end
                KIND_CHECK_B: begin
                    s1_reg[2] <= n1;
                    s2_reg[2] <= n2;
                end
                default: begin
                    s1_reg[0] <= n1;
                    s2_reg[0] <= n2;
                end
            endcase
        end
    end

    assign hash_offset = s1_reg[0];
    assign hash_a      = s1_reg[1];
    assign hash_b      = s1_reg[2];
endmodule

>>> hw/rtl/mpqh_mod.sv
// ----------------------------------------------------------------------------
// mpqh_mod
// Bit-serial remainder unit: a 32-bit hash modulo the live table size.
// ----------------------------------------------------------------------------
module mpqh_mod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mpqh_pkg::HASH_W-1:0] dividend,
    input  logic [mpqh_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [mpqh_pkg::SLOT_W-1:0] rem
);
    import mpqh_pkg::*;

    logic [HASH_W-1:0]    quo_reg;
    logic [SIZE_W-1:0]    rem_reg, div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W-1:0]    rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {rem_reg, quo_reg[HASH_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            trial = trial - {1'b0, div_reg};
        end
        rem_next = trial[SIZE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(HASH_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[SLOT_W-1:0];
endmodule

>>> hw/rtl/mpq_hash_linear_probe_table.sv
// ----------------------------------------------------------------------------
// mpq_hash_linear_probe_table
// One-way hash table with linear probing over a 1024-slot store.
// ----------------------------------------------------------------------------
// Sequence: each key byte is folded in the shared fold unit for the offset,
// check A and check B hashes in turn before the next byte is taken. A final
// byte then takes the start-slot remainder in the divider, a read and a
// compare per probed slot, and the load of the result register. A remove
// goes straight from its beat to the emit state. Reset starts a pass that
// clears all 1024 slots of the store; the input is not ready until it ends.
// ----------------------------------------------------------------------------
module mpq_hash_linear_probe_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mpqh_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mpqh_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mpqh_pkg::*;

    fsm_t state_reg, state_next;

    logic [10:0]       ts_reg;
    logic [SIZE_W-1:0] live_n;

    // Beat registers of the key in work.
    logic [1:0]        cmd_reg;
    logic [7:0]        ch_reg;
    logic              last_reg;
    logic [1:0]        kind_reg;
    logic [HASH_W-1:0] ha_reg, hb_reg;
    logic [SLOT_W-1:0] pos_reg, clr_reg;
    logic [SIZE_W-1:0] cnt_reg;
    out_beat_t         pend_reg, out_data_reg;
    logic              out_valid_reg;

    logic              accept, out_free, cfg_wr;
    logic [7:0]        ch_up;
    fold_ctrl_t        fold_ctrl;
    logic [HASH_W-1:0] hash_offset, hash_a, hash_b;
    logic              mod_start, mod_done;
    logic [SLOT_W-1:0] mod_rem;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    slot_entry_t       ram_wdata, ram_rdata;

    logic              hit, last_probe, idx_bad;
    logic [SLOT_W-1:0] pos_inc;

    // The slot count in use: zero acts as one, anything above the store acts
    // as the full store.
    always_comb begin
        if (ts_reg == '0) begin
            live_n = SIZE_W'(1);
        end else if (ts_reg > 11'(SLOTS)) begin
            live_n = SIZE_W'(SLOTS);
        end else begin
            live_n = SIZE_W'(ts_reg);
        end
    end

    // Configuration port. Only the table size register exists.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_TABLE_SIZE);
    assign prdata = (paddr == REG_TABLE_SIZE) ? {21'd0, ts_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg <= TABLE_SIZE_RESET;
        end else if (cfg_wr) begin
            ts_reg <= pwdata[10:0];
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign ch_up    = (s_data.key_byte >= 8'h61 && s_data.key_byte <= 8'h7A) ?
                      s_data.key_byte - 8'h20 : s_data.key_byte;
    assign idx_bad  = {1'b0, s_data.slot_index} >= live_n;

    // A slot matches when both check hashes agree; empty slots hold all ones.
    assign hit        = (ram_rdata.chk_a == ha_reg) && (ram_rdata.chk_b == hb_reg);
    assign last_probe = (cnt_reg == live_n - 1'b1);
    assign pos_inc    = ({1'b0, pos_reg} + 1'b1 == live_n) ? '0 : pos_reg + 1'b1;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR: begin
                if (clr_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (accept) begin
                    if (s_data.cmd == CMD_INSERT || s_data.cmd == CMD_LOOKUP) begin
                        state_next = FSM_FOLD;
                    end else if (s_data.cmd == CMD_REMOVE) begin
                        state_next = FSM_EMIT;
                    end
                end
            end
            FSM_FOLD: begin
                if (kind_reg == KIND_CHECK_B) begin
                    state_next = last_reg ? FSM_HASH : FSM_IDLE;
                end
            end
            FSM_HASH: state_next = FSM_MOD;
            FSM_MOD: begin
                if (mod_done) begin
                    state_next = FSM_PROBE_RD;
                end
            end
            FSM_PROBE_RD: state_next = FSM_PROBE_CMP;
            FSM_PROBE_CMP: begin
                if ((cmd_reg == CMD_INSERT && !ram_rdata.used) || hit || last_probe) begin
                    state_next = FSM_EMIT;
                end else begin
                    state_next = FSM_PROBE_RD;
                end
            end
            FSM_EMIT: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Output logic of the sequencer: handshake, fold unit, divider and RAM.
    always_comb begin
        s_ready           = 1'b0;
        fold_ctrl.step    = 1'b0;
        fold_ctrl.restart = 1'b0;
        fold_ctrl.kind    = kind_reg;
        mod_start         = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = pos_reg;
        ram_wdata         = '1;
        ram_raddr         = pos_reg;
        unique case (state_reg)
            FSM_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = clr_reg;
                ram_wdata.used = 1'b0;
            end
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (accept && s_data.cmd == CMD_REMOVE && !idx_bad) begin
                    ram_we         = 1'b1;
                    ram_waddr      = s_data.slot_index;
                    ram_wdata.used = 1'b0;
                end
            end
            FSM_FOLD: fold_ctrl.step = 1'b1;
            FSM_HASH: begin
                fold_ctrl.restart = 1'b1;
                mod_start         = 1'b1;
            end
            FSM_PROBE_CMP: begin
                if (cmd_reg == CMD_INSERT && !ram_rdata.used) begin
                    ram_we          = 1'b1;
                    ram_wdata.used  = 1'b1;
                    ram_wdata.chk_a = ha_reg;
                    ram_wdata.chk_b = hb_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == FSM_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == FSM_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the key and probe walk.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    cmd_reg  <= s_data.cmd;
                    ch_reg   <= ch_up;
                    last_reg <= s_data.last_byte;
                    kind_reg <= KIND_OFFSET;
                    if (idx_bad) begin
                        pend_reg.status <= ST_BAD_SLOT;
                        pend_reg.slot   <= '0;
                    end else begin
                        pend_reg.status <= ST_REMOVED;
                        pend_reg.slot   <= s_data.slot_index;
                    end
                end
            end
            FSM_FOLD: kind_reg <= kind_reg + 1'b1;
            FSM_HASH: begin
                ha_reg <= hash_a;
                hb_reg <= hash_b;
            end
            FSM_MOD: begin
                pos_reg <= mod_rem;
                cnt_reg <= '0;
            end
            FSM_PROBE_CMP: begin
                pos_reg <= pos_inc;
                cnt_reg <= cnt_reg + 1'b1;
                if (cmd_reg == CMD_INSERT && !ram_rdata.used) begin
                    pend_reg.status <= ST_INSERTED;
                    pend_reg.slot   <= pos_reg;
                end else if (cmd_reg == CMD_INSERT && hit) begin
                    pend_reg.status <= ST_DUPLICATE;
                    pend_reg.slot   <= '0;
                end else if (cmd_reg == CMD_INSERT) begin
                    pend_reg.status <= ST_FULL;
                    pend_reg.slot   <= '0;
                end else if (hit) begin
                    pend_reg.status <= ST_FOUND;
                    pend_reg.slot   <= pos_reg;
                end else begin
                    pend_reg.status <= ST_NOT_FOUND;
                    pend_reg.slot   <= '0;
                end
            end
            FSM_EMIT: begin
                if (out_free) begin
                    out_data_reg <= pend_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    mpqh_fold u_fold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (fold_ctrl),
        .ch          (ch_reg),
        .hash_offset (hash_offset),
        .hash_a      (hash_a),
        .hash_b      (hash_b)
    );

    mpqh_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (hash_offset),
        .divisor  (live_n),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    mpqh_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The probe walk never leaves the live part of the store.
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_PROBE_CMP |-> {1'b0, pos_reg} < live_n)
        else $error("probe position beyond live table size");

    // The start slot from the divider is always a live slot.
    a_start_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_MOD && mod_done) |-> {1'b0, mod_rem} < live_n)
        else $error("start slot beyond live table size");

    // The store is written only while clearing, on a remove or on an insert.
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == FSM_CLEAR || state_reg == FSM_IDLE ||
                    state_reg == FSM_PROBE_CMP))
        else $error("slot store written outside an allowed state");

    // A result leaves the sequencer only when the output register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && state_reg == FSM_EMIT) |=> state_reg == FSM_EMIT)
        else $error("pending result lost while output stalled");
endmodule
